@@ hdl/hpe_pkg.sv @@
`timescale 1ns / 1ps

package hpe_pkg;

  // histogram shape
  localparam int NUM_BINS = 10;
  localparam int IDX_W    = 4;
  localparam int IN_W     = 32;

  // result and register widths
  localparam int RES_W = 20;
  localparam int CFG_W = 20;

  // percentile targets, in percent
  localparam int NUM_PCT = 3;
  localparam int TGT_W   = 7;
  localparam logic [TGT_W-1:0] PCT_SCALE = 7'd100;
  localparam logic [TGT_W-1:0] PCT_TARGET [NUM_PCT] = '{7'd50, 7'd90, 7'd99};

  // bounds of the open-ended top bucket
  localparam logic [RES_W-1:0] TOP_LOWER     = 20'd16000;
  localparam logic [CFG_W-1:0] TOP_UPPER_RST = 20'd32000;

  // pipeline depth: prefix sums, lane front end, one stage per quotient bit
  localparam int PRE_STAGES  = 3;
  localparam int LANE_STAGES = 3;
  localparam int DIV_STEPS   = RES_W;
  localparam int NUM_STAGES  = PRE_STAGES + LANE_STAGES + DIV_STEPS;

  typedef struct packed {
    logic [IN_W-1:0] count_b0;
    logic [IN_W-1:0] count_b1;
    logic [IN_W-1:0] count_b2;
    logic [IN_W-1:0] count_b3;
    logic [IN_W-1:0] count_b4;
    logic [IN_W-1:0] count_b5;
    logic [IN_W-1:0] count_b6;
    logic [IN_W-1:0] count_b7;
    logic [IN_W-1:0] count_b8;
    logic [IN_W-1:0] count_b9;
  } hpe_in_t;

  typedef struct packed {
    logic [RES_W-1:0] median_us;
    logic [RES_W-1:0] p90_us;
    logic [RES_W-1:0] p99_us;
  } hpe_out_t;

  // lower edge of a bucket in microseconds
  function automatic logic [RES_W-1:0] lower_edge(input logic [IDX_W-1:0] idx);
    logic [RES_W-1:0] edge_us;
    case (idx)
      4'd0:    edge_us = 20'd0;
      4'd1:    edge_us = 20'd64;
      4'd2:    edge_us = 20'd128;
      4'd3:    edge_us = 20'd256;
      4'd4:    edge_us = 20'd512;
      4'd5:    edge_us = 20'd1000;
      4'd6:    edge_us = 20'd2000;
      4'd7:    edge_us = 20'd4000;
      4'd8:    edge_us = 20'd8000;
      4'd9:    edge_us = TOP_LOWER;
      default: edge_us = 20'd0;
    endcase
    return edge_us;
  endfunction

  // bucket width; top bucket saturates at zero for a small upper bound
  function automatic logic [RES_W-1:0] bin_width(input logic [IDX_W-1:0] idx,
                                                 input logic [CFG_W-1:0] top_upper);
    logic [RES_W-1:0] w;
    case (idx)
      4'd0:    w = 20'd64;
      4'd1:    w = 20'd64;
      4'd2:    w = 20'd128;
      4'd3:    w = 20'd256;
      4'd4:    w = 20'd488;
      4'd5:    w = 20'd1000;
      4'd6:    w = 20'd2000;
      4'd7:    w = 20'd4000;
      4'd8:    w = 20'd8000;
      4'd9:    w = (top_upper > TOP_LOWER) ? (top_upper - TOP_LOWER) : 20'd0;
      default: w = 20'd0;
    endcase
    return w;
  endfunction

endpackage

@@ hdl/hpe_prefix.sv @@
`timescale 1ns / 1ps

module hpe_prefix #(
  parameter int CW = 32
) (
  input  logic                                         clk_i,
  input  logic [hpe_pkg::PRE_STAGES-1:0]               en_i,
  input  hpe_pkg::hpe_in_t                             in_item_i,
  output logic [CW+3:0]                                total_o,
  output logic [hpe_pkg::NUM_BINS-1:0][CW+10:0]        cum100_o,
  output logic [hpe_pkg::NUM_BINS-1:0][CW+6:0]         cnt100_o
);

  localparam int SUM_W = CW + 4;
  localparam int SW    = CW + 11;
  localparam int DW    = CW + 7;
  localparam int HALF  = hpe_pkg::NUM_BINS / 2;

  logic [hpe_pkg::NUM_BINS-1:0][CW-1:0]    cnt_in;
  logic [hpe_pkg::NUM_BINS-1:0][SUM_W-1:0] pre_d;
  logic [hpe_pkg::NUM_BINS-1:0][CW-1:0]    cnt1_q;
  logic [hpe_pkg::NUM_BINS-1:0][SUM_W-1:0] pre_q;
  logic [hpe_pkg::NUM_BINS-1:0][CW-1:0]    cnt2_q;
  logic [hpe_pkg::NUM_BINS-1:0][SUM_W-1:0] cum_q;
  logic [hpe_pkg::NUM_BINS-1:0][SW-1:0]    cum100_q;
  logic [hpe_pkg::NUM_BINS-1:0][DW-1:0]    cnt100_q;
  logic [SUM_W-1:0]                        total_q;

  // counts cut to the configured count width
  always_comb begin
    cnt_in[0] = in_item_i.count_b0[CW-1:0];
    cnt_in[1] = in_item_i.count_b1[CW-1:0];
    cnt_in[2] = in_item_i.count_b2[CW-1:0];
    cnt_in[3] = in_item_i.count_b3[CW-1:0];
    cnt_in[4] = in_item_i.count_b4[CW-1:0];
    cnt_in[5] = in_item_i.count_b5[CW-1:0];
    cnt_in[6] = in_item_i.count_b6[CW-1:0];
    cnt_in[7] = in_item_i.count_b7[CW-1:0];
    cnt_in[8] = in_item_i.count_b8[CW-1:0];
    cnt_in[9] = in_item_i.count_b9[CW-1:0];
  end

  // running sums within the lower and the upper half
  always_comb begin
    for (int i = 0; i < hpe_pkg::NUM_BINS; i++) begin
      if (i == 0 || i == HALF) begin
        pre_d[i] = SUM_W'(cnt_in[i]);
      end else begin
        pre_d[i] = pre_d[(i == 0) ? 0 : i-1] + SUM_W'(cnt_in[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cnt1_q <= cnt_in;
      pre_q  <= pre_d;
    end
  end

  // upper half gets the lower half's sum added
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      cnt2_q <= cnt1_q;
      for (int i = 0; i < hpe_pkg::NUM_BINS; i++) begin
        cum_q[i] <= (i < HALF) ? pre_q[i] : pre_q[i] + pre_q[HALF-1];
      end
    end
  end

  // scale cumulative and own counts to percent units
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      total_q <= cum_q[hpe_pkg::NUM_BINS-1];
      for (int i = 0; i < hpe_pkg::NUM_BINS; i++) begin
        cum100_q[i] <= SW'(cum_q[i]) * SW'(hpe_pkg::PCT_SCALE);
        cnt100_q[i] <= DW'(cnt2_q[i]) * DW'(hpe_pkg::PCT_SCALE);
      end
    end
  end

  assign total_o  = total_q;
  assign cum100_o = cum100_q;
  assign cnt100_o = cnt100_q;

endmodule

@@ hdl/hpe_div.sv @@
`timescale 1ns / 1ps

module hpe_div #(
  parameter int DW = 39,
  parameter int TW = 6
) (
  input  logic                                clk_i,
  input  logic [hpe_pkg::DIV_STEPS-1:0]       en_i,
  input  logic [DW+hpe_pkg::DIV_STEPS-1:0]    prod_i,
  input  logic [DW-1:0]                       den_i,
  input  logic [TW-1:0]                       tag_i,
  output logic [hpe_pkg::DIV_STEPS-1:0]       quo_o,
  output logic [TW-1:0]                       tag_o
);

  localparam int QW = hpe_pkg::DIV_STEPS;

  // one quotient bit per stage; the remainder stays below the divisor
  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_q;
    logic [QW-1:0] low_q;
    logic [QW-1:0] quo_q;
    logic [DW-1:0] den_q;
    logic [TW-1:0] tag_q;

    if (j == 0) begin : g_first
      assign rem_in = prod_i[DW+QW-1:QW];
      assign low_in = prod_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = g_step[j-1].rem_q;
      assign low_in = g_step[j-1].low_q;
      assign quo_in = g_step[j-1].quo_q;
      assign den_in = g_step[j-1].den_q;
      assign tag_in = g_step[j-1].tag_q;
    end

    assign trial = {rem_in, low_in[QW-1-j]};
    assign ge    = (trial >= {1'b0, den_in});
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low_q <= low_in;
        quo_q <= {quo_in[QW-2:0], ge};
        den_q <= den_in;
        tag_q <= tag_in;
      end
    end
  end

  assign quo_o = g_step[QW-1].quo_q;
  assign tag_o = g_step[QW-1].tag_q;

endmodule

@@ hdl/hpe_lane.sv @@
`timescale 1ns / 1ps

module hpe_lane #(
  parameter int CW = 32
) (
  input  logic                                                clk_i,
  input  logic [hpe_pkg::LANE_STAGES+hpe_pkg::DIV_STEPS-1:0]  en_i,
  input  logic [hpe_pkg::TGT_W-1:0]                           target_i,
  input  logic [hpe_pkg::CFG_W-1:0]                           top_upper_i,
  input  logic [CW+3:0]                                       total_i,
  input  logic [hpe_pkg::NUM_BINS-1:0][CW+10:0]               cum100_i,
  input  logic [hpe_pkg::NUM_BINS-1:0][CW+6:0]                cnt100_i,
  output logic [hpe_pkg::RES_W-1:0]                           res_o
);

  localparam int SW = CW + 11;
  localparam int DW = CW + 7;
  localparam int PW = DW + hpe_pkg::DIV_STEPS;
  localparam int TW = hpe_pkg::IDX_W + 2;

  logic [SW-1:0]                        need_q;
  logic [hpe_pkg::NUM_BINS-1:0][SW-1:0] cum100_q;
  logic [hpe_pkg::NUM_BINS-1:0][DW-1:0] cnt100_q;

  logic [hpe_pkg::NUM_BINS-1:0]         hit;
  logic [hpe_pkg::NUM_BINS-1:0][SW-1:0] prev100;
  logic [hpe_pkg::IDX_W-1:0]            sel;
  logic [SW-1:0]                        num_full;

  logic [DW-1:0]                        num_q;
  logic [DW-1:0]                        den_q;
  logic [hpe_pkg::IDX_W-1:0]            idx_q;
  logic                                 found_q;
  logic                                 zero_q;

  logic [PW-1:0]                        prod_q;
  logic [DW-1:0]                        den6_q;
  logic [TW-1:0]                        tag6_q;

  logic [hpe_pkg::DIV_STEPS-1:0]        quo;
  logic [TW-1:0]                        tag_out;
  logic [hpe_pkg::IDX_W-1:0]            idx_out;
  logic                                 found_out;
  logic                                 zero_out;

  // samples needed to reach this lane's target, in percent units
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      need_q   <= SW'(total_i) * SW'(target_i);
      cum100_q <= cum100_i;
      cnt100_q <= cnt100_i;
    end
  end

  // first nonzero bucket whose cumulative count reaches the target
  always_comb begin
    for (int i = 0; i < hpe_pkg::NUM_BINS; i++) begin
      hit[i]     = (cnt100_q[i] != '0) && (cum100_q[i] >= need_q);
      prev100[i] = (i == 0) ? '0 : cum100_q[(i == 0) ? 0 : i-1];
    end
    sel = '0;
    for (int i = hpe_pkg::NUM_BINS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel = hpe_pkg::IDX_W'(i);
      end
    end
    num_full = need_q - prev100[sel];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      num_q   <= num_full[DW-1:0];
      den_q   <= cnt100_q[sel];
      idx_q   <= sel;
      found_q <= |hit;
      zero_q  <= (need_q == '0);
    end
  end

  // scale the offset into the bucket by the bucket width
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      prod_q <= PW'(num_q) * PW'(hpe_pkg::bin_width(idx_q, top_upper_i));
      den6_q <= den_q;
      tag6_q <= {zero_q, found_q, idx_q};
    end
  end

  hpe_div #(
    .DW (DW),
    .TW (TW)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (en_i[hpe_pkg::LANE_STAGES +: hpe_pkg::DIV_STEPS]),
    .prod_i (prod_q),
    .den_i  (den6_q),
    .tag_i  (tag6_q),
    .quo_o  (quo),
    .tag_o  (tag_out)
  );

  assign {zero_out, found_out, idx_out} = tag_out;

  // empty histogram gives zero, an unreached target the top lower edge
  always_comb begin
    if (zero_out) begin
      res_o = '0;
    end else if (!found_out) begin
      res_o = hpe_pkg::TOP_LOWER;
    end else begin
      res_o = hpe_pkg::lower_edge(idx_out) + quo;
    end
  end

endmodule

@@ hdl/histogram_percentile_estimator_top.sv @@
`timescale 1ns / 1ps

// Histogram percentile estimator: takes one item of ten bucket counts and
// returns one item with the interpolated 50th, 90th and 99th percentiles.
// Input channel in_valid_i / in_ready_o / in_item_i and output channel
// out_valid_o / out_ready_i / out_item_o use valid-ready; an item moves at
// a clock edge where both are high.
// cfg_we_i writes cfg_wdata_i to the top bucket's upper bound (reset 32000);
// write it only while no item is in flight.
// The item passes 3 prefix-sum stages, 3 select/multiply stages and 20
// divider stages, then the output register. Throughput: one item per cycle
// while the receiver takes results; the three percentile lanes and their
// 20-stage restoring dividers run in parallel.
// When the receiver stalls, results stay in the output register and the
// pipeline keeps taking items until every stage holds one; then in_ready_o
// drops. Reset empties the pipeline and restores the upper bound.
module histogram_percentile_estimator_top #(
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hpe_pkg::hpe_in_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hpe_pkg::hpe_out_t             out_item_o,
  input  logic                          cfg_we_i,
  input  logic [hpe_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int CW  = (COUNT_BITS < hpe_pkg::IN_W) ? COUNT_BITS : hpe_pkg::IN_W;
  localparam int NST = hpe_pkg::NUM_STAGES;

  logic [hpe_pkg::CFG_W-1:0]               top_upper_q;
  logic [NST:0]                            adv;
  logic [NST-1:0]                          vld_d, vld_q;
  logic                                    out_valid_d, out_valid_q;
  hpe_pkg::hpe_out_t                       out_item_q;

  logic [CW+3:0]                           total;
  logic [hpe_pkg::NUM_BINS-1:0][CW+10:0]   cum100;
  logic [hpe_pkg::NUM_BINS-1:0][CW+6:0]    cnt100;
  logic [hpe_pkg::NUM_PCT-1:0][hpe_pkg::RES_W-1:0] lane_res;

  // top bucket upper bound
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_upper_q <= hpe_pkg::TOP_UPPER_RST;
    end else if (cfg_we_i) begin
      top_upper_q <= cfg_wdata_i;
    end
  end

  // a stage advances when empty or when the stage after it advances
  always_comb begin
    adv[NST] = !out_valid_q || out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = adv[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NST; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
    out_valid_d = adv[NST] ? vld_q[NST-1] : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // shared prefix sums
  hpe_prefix #(
    .CW (CW)
  ) u_prefix (
    .clk_i     (clk_i),
    .en_i      (adv[hpe_pkg::PRE_STAGES-1:0]),
    .in_item_i (in_item_i),
    .total_o   (total),
    .cum100_o  (cum100),
    .cnt100_o  (cnt100)
  );

  // one lane per percentile
  for (genvar p = 0; p < hpe_pkg::NUM_PCT; p++) begin : g_lane
    hpe_lane #(
      .CW (CW)
    ) u_lane (
      .clk_i       (clk_i),
      .en_i        (adv[NST-1:hpe_pkg::PRE_STAGES]),
      .target_i    (hpe_pkg::PCT_TARGET[p]),
      .top_upper_i (top_upper_q),
      .total_i     (total),
      .cum100_i    (cum100),
      .cnt100_i    (cnt100),
      .res_o       (lane_res[p])
    );
  end

  // merge the lane results into the output item
  always_ff @(posedge clk_i) begin
    if (adv[NST] && vld_q[NST-1]) begin
      out_item_q.median_us <= lane_res[0];
      out_item_q.p90_us    <= lane_res[1];
      out_item_q.p99_us    <= lane_res[2];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hdl/hpe_checker.sv @@
`timescale 1ns / 1ps

module hpe_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_ready_o,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  hpe_pkg::hpe_out_t out_item_o
);

  // a stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // input back-pressure only comes from a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

  // percentiles never decrease with the target
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.median_us <= out_item_o.p90_us) &&
                    (out_item_o.p90_us <= out_item_o.p99_us))
    else $error("percentiles out of order");

  // empty pipeline after reset gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind histogram_percentile_estimator_top hpe_checker u_hpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
